FILE: rtl/mrde_pkg.sv
// Shared types and constants for the monochrome raster draw engine.
`default_nettype none
package mrde_pkg;

  typedef enum logic [2:0] {
    CMD_POINT  = 3'd0,
    CMD_LINE   = 3'd1,
    CMD_CIRCLE = 3'd2,
    CMD_FILL   = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    PIX_ERASE  = 2'd0,
    PIX_SET    = 2'd1,
    PIX_TOGGLE = 2'd2,
    PIX_KEEP   = 2'd3
  } pix_e;

  // One classified command as it travels through the queue.
  typedef struct packed {
    logic [2:0] cmd;
    logic [6:0] xa;
    logic [5:0] ya;
    logic [6:0] xb;
    logic [5:0] yb;
    logic [6:0] rad;
    logic [1:0] op;
    logic [2:0] page;
  } mrde_cmd_t;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINE,
    ST_CIRC,
    ST_FILL,
    ST_CLEAR,
    ST_READ,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_OUT
  } back_state_e;

endpackage
`default_nettype wire

FILE: rtl/mrde_front.sv
// Front end: accepts command words, drops unused and no-change ones and queues the rest.
`default_nettype none
module mrde_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mrde_pkg::mrde_cmd_t in_cmd_i,
  output logic                    q_valid_o,
  input  wire logic               q_ready_i,
  output mrde_pkg::mrde_cmd_t     q_cmd_o
);
  import mrde_pkg::*;

  mrde_cmd_t  mem_q [QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       keep, push, pop;

  // Unused command codes and no-change drawing cause no work at all.
  always_comb begin
    unique case (in_cmd_i.cmd) inside
      CMD_CLEAR, CMD_READ: keep = 1'b1;
      CMD_POINT, CMD_LINE, CMD_CIRCLE, CMD_FILL: keep = (in_cmd_i.op != PIX_KEEP);
      default: keep = 1'b0;
    endcase
  end

  assign in_ready  = (cnt_q != 2'd2);
  assign push      = in_valid && in_ready && keep;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/mrde_back.sv
// Back end: walks lines, circles and rectangles, clears and reads back, and edits the framebuffer.
`default_nettype none
module mrde_back #(
  parameter int unsigned SCREEN_WIDTH = 128,
  parameter int unsigned SCREEN_PAGES = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  output logic                     q_ready_o,
  input  wire mrde_pkg::mrde_cmd_t q_cmd_i,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               read_data_o
);
  import mrde_pkg::*;

  localparam int unsigned Depth = SCREEN_WIDTH * SCREEN_PAGES;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned Height = SCREEN_PAGES * 8;

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  back_state_e state_q, state_d, ret_q, ret_d;
  mrde_cmd_t   c_q, c_d;
  // Walk registers, signed wide enough for circle coordinates and terms.
  logic signed [10:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [10:0] ex_q, ex_d, ey_q, ey_d, dx_q, dx_d, dy_q, dy_d;
  logic signed [10:0] sp_q, sp_d;
  logic signed [1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [7:0]         k_q, k_d;
  logic signed [12:0] f_q, f_d;
  logic [2:0]         oct_q, oct_d;
  logic [AW:0]        clr_q, clr_d;
  logic signed [10:0] px_q, px_d, py_q, py_d;
  logic [7:0]         out_q, out_d;
  logic               out_v_q, out_v_d;

  logic [AW-1:0]      addr;
  logic [AW-1:0]      waddr;
  logic [7:0]         wdata;
  logic               we;
  logic               pin;
  logic signed [10:0] ox, oy;
  logic [7:0]         bitm;

  assign pin = (px_q >= 0) && (py_q >= 0) && (px_q < $signed(11'(SCREEN_WIDTH)))
               && (py_q < $signed(11'(Height)));
  // Only meaningful while the pixel is on screen.
  assign addr = AW'(32'(py_q[10:3]) * SCREEN_WIDTH + 32'(px_q[10:0]));
  assign bitm = 8'h01 << py_q[2:0];

  always_comb begin
    case (oct_q)
      3'd0: begin ox = cx_q + ex_q; oy = cy_q + ey_q; end
      3'd1: begin ox = cx_q - ex_q; oy = cy_q + ey_q; end
      3'd2: begin ox = cx_q + ex_q; oy = cy_q - ey_q; end
      3'd3: begin ox = cx_q - ex_q; oy = cy_q - ey_q; end
      3'd4: begin ox = cx_q + ey_q; oy = cy_q + ex_q; end
      3'd5: begin ox = cx_q - ey_q; oy = cy_q + ex_q; end
      3'd6: begin ox = cx_q + ey_q; oy = cy_q - ex_q; end
      default: begin ox = cx_q - ey_q; oy = cy_q - ex_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[addr];
  end

  always_comb begin
    state_d = state_q; ret_d = ret_q; c_d = c_q;
    cx_d = cx_q; cy_d = cy_q; ex_d = ex_q; ey_d = ey_q; dx_d = dx_q; dy_d = dy_q;
    sp_d = sp_q; sx_d = sx_q; sy_d = sy_q; k_d = k_q; f_d = f_q; oct_d = oct_q;
    clr_d = clr_q; px_d = px_q; py_d = py_q; out_d = out_q; out_v_d = out_v_q;
    q_ready_o = 1'b0; we = 1'b0; waddr = addr; wdata = rdata_q;
    if (out_v_q && out_ready) out_v_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        q_ready_o = !out_v_q;
        if (q_valid_i && !out_v_q) begin
          c_d = q_cmd_i;
          px_d = 11'(q_cmd_i.xa); py_d = 11'(q_cmd_i.ya);
          cx_d = 11'(q_cmd_i.xa); cy_d = 11'(q_cmd_i.ya);
          unique case (q_cmd_i.cmd)
            CMD_POINT: begin state_d = ST_RMW_RD; ret_d = ST_IDLE; end
            CMD_LINE: begin
              dx_d = 11'(q_cmd_i.xb) - 11'(q_cmd_i.xa);
              dy_d = 11'(q_cmd_i.yb) - 11'(q_cmd_i.ya);
              sx_d = (q_cmd_i.xb > q_cmd_i.xa) ? 2'sd1 :
                     (q_cmd_i.xb < q_cmd_i.xa) ? -2'sd1 : 2'sd0;
              sy_d = (q_cmd_i.yb > q_cmd_i.ya) ? 2'sd1 :
                     (q_cmd_i.yb < q_cmd_i.ya) ? -2'sd1 : 2'sd0;
              if (dx_d < 0) dx_d = -dx_d;
              if (dy_d < 0) dy_d = -dy_d;
              sp_d = (dx_d > dy_d) ? dx_d : dy_d;
              ex_d = '0; ey_d = '0; k_d = '0;
              state_d = ST_RMW_RD; ret_d = ST_LINE;
            end
            CMD_CIRCLE: begin
              ex_d = 11'(q_cmd_i.rad); ey_d = '0;
              f_d = 13'sd3 - (13'(q_cmd_i.rad) <<< 1);
              oct_d = '0; state_d = ST_CIRC;
            end
            CMD_FILL: begin
              if (q_cmd_i.xa <= q_cmd_i.xb && q_cmd_i.ya <= q_cmd_i.yb) begin
                state_d = ST_RMW_RD; ret_d = ST_FILL;
              end
            end
            CMD_CLEAR: begin clr_d = '0; state_d = ST_CLEAR; end
            CMD_READ: begin
              px_d = 11'(q_cmd_i.xa); py_d = 11'({q_cmd_i.page, 3'b000});
              state_d = ST_READ;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RMW_RD: begin
        if (pin) state_d = ST_RMW_WR;
        else state_d = ret_q;
      end
      ST_RMW_WR: begin
        we = 1'b1;
        case (c_q.op)
          PIX_ERASE:  wdata = rdata_q & ~bitm;
          PIX_SET:    wdata = rdata_q | bitm;
          PIX_TOGGLE: wdata = rdata_q ^ bitm;
          default:    wdata = rdata_q;
        endcase
        state_d = ret_q;
      end
      ST_LINE: begin
        // Step after each plot; distance+2 plots in all.
        if (11'(k_q) == sp_q + 11'sd1) state_d = ST_IDLE;
        else begin
          k_d = k_q + 8'd1;
          ex_d = ex_q + dx_q; ey_d = ey_q + dy_q;
          if (ex_q + dx_q > sp_q) begin
            ex_d = ex_q + dx_q - sp_q; cx_d = cx_q + 11'(sx_q);
          end
          if (ey_q + dy_q > sp_q) begin
            ey_d = ey_q + dy_q - sp_q; cy_d = cy_q + 11'(sy_q);
          end
          px_d = (ex_q + dx_q > sp_q) ? cx_q + 11'(sx_q) : cx_q;
          py_d = (ey_q + dy_q > sp_q) ? cy_q + 11'(sy_q) : cy_q;
          state_d = ST_RMW_RD; ret_d = ST_LINE;
        end
      end
      ST_CIRC: begin
        // ex holds a, ey holds b; eight symmetric plots then one midpoint step.
        if (ex_q < ey_q) state_d = ST_IDLE;
        else if (oct_q == 3'd7 && ret_q == ST_CIRC && k_q == 8'd1) begin
          k_d = 8'd0; oct_d = '0;
          if (f_q >= 0) begin
            ex_d = ex_q - 11'sd1;
            f_d = f_q - (13'(ex_q - 11'sd1) <<< 2) + (13'(ey_q + 11'sd1) <<< 2) + 13'sd2;
          end else f_d = f_q + (13'(ey_q + 11'sd1) <<< 2) + 13'sd2;
          ey_d = ey_q + 11'sd1;
        end else begin
          if (k_q == 8'd1) oct_d = oct_q + 3'd1;
          px_d = (k_q == 8'd1) ? px_q : ox;
          py_d = (k_q == 8'd1) ? py_q : oy;
          if (k_q == 8'd0) begin
            k_d = 8'd1; state_d = ST_RMW_RD; ret_d = ST_CIRC;
          end else begin
            k_d = (oct_q == 3'd7) ? 8'd1 : 8'd0;
          end
        end
      end
      ST_FILL: begin
        if (py_q < 11'(c_q.yb)) py_d = py_q + 11'sd1;
        else begin
          py_d = 11'(c_q.ya); px_d = px_q + 11'sd1;
        end
        if (px_q == 11'(c_q.xb) && py_q == 11'(c_q.yb)) state_d = ST_IDLE;
        else state_d = ST_RMW_RD;
      end
      ST_CLEAR: begin
        we = 1'b1; waddr = clr_q[AW-1:0]; wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(Depth - 1)) state_d = ST_IDLE;
      end
      ST_READ: state_d = ST_OUT;
      ST_OUT: begin
        out_d = (c_q.xa < SCREEN_WIDTH && c_q.page < SCREEN_PAGES) ? rdata_q : 8'h00;
        out_v_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; ret_q <= ST_IDLE; clr_q <= '0; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; clr_q <= clr_d; out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; cx_q <= cx_d; cy_q <= cy_d; ex_q <= ex_d; ey_q <= ey_d;
    dx_q <= dx_d; dy_q <= dy_d; sp_q <= sp_d; sx_q <= sx_d; sy_q <= sy_d;
    k_q <= (state_q == ST_IDLE && state_d == ST_CIRC) ? 8'd0 : k_d;
    f_q <= f_d; oct_q <= oct_d; px_q <= px_d; py_q <= py_d; out_q <= out_d;
  end

  assign out_valid   = out_v_q;
  assign read_data_o = out_q;
endmodule
`default_nettype wire

FILE: rtl/monochrome_raster_draw_engine_top.sv
// Top level of the monochrome raster draw engine.
// Each on-screen plotted pixel is a read-modify-write of its framebuffer byte; a clear writes every byte in turn,
// and a read passes through a read state and an output state before the result word is offered.
// The back end works on one command at a time, taken from the head of the queue;
// the two-entry queue lets the front accept words while drawing goes on.
// After reset a clearing pass over all SCREEN_WIDTH*SCREEN_PAGES bytes runs before any work.
`default_nettype none
module monochrome_raster_draw_engine_top #(
  parameter int unsigned SCREEN_WIDTH = 128,
  parameter int unsigned SCREEN_PAGES = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] cmd_i,
  input  wire logic [6:0] x_first_i,
  input  wire logic [5:0] y_first_i,
  input  wire logic [6:0] x_second_i,
  input  wire logic [5:0] y_second_i,
  input  wire logic [6:0] radius_i,
  input  wire logic [1:0] pixel_op_i,
  input  wire logic [2:0] read_page_i,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      read_data_o
);
  import mrde_pkg::*;

  mrde_cmd_t in_cmd, q_cmd;
  logic      q_valid, q_ready;

  assign in_cmd = '{cmd: cmd_i, xa: x_first_i, ya: y_first_i, xb: x_second_i,
                    yb: y_second_i, rad: radius_i, op: pixel_op_i, page: read_page_i};

  mrde_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  mrde_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_PAGES(SCREEN_PAGES)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .out_valid, .out_ready, .read_data_o
  );
endmodule
`default_nettype wire
